FILE: hdl/rcfp_pkg.sv
// Shared constants and types for the RC channel frame parser.
package rcfp_pkg;

	// Configuration register port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENDER_ID    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENDER_CLASS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_OFFSET  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_BIAS     = 3'd5;

	// Register reset values
	localparam logic [7:0]  RST_START_BYTE   = 8'hFE;
	localparam logic [7:0]  RST_SENDER_ID    = 8'h01;
	localparam logic [7:0]  RST_SENDER_CLASS = 8'h01;
	localparam logic [7:0]  RST_FRAME_ID     = 8'h23;
	localparam logic [4:0]  RST_DATA_OFFSET  = 5'd10;
	localparam logic [15:0] RST_PWM_BIAS     = 16'd980;

	// Frame layout
	localparam logic [4:0] OFFSET_MAX    = 5'd31;
	localparam logic [4:0] HDR_ID_POS    = 5'd3;
	localparam logic [4:0] HDR_CLASS_POS = 5'd4;
	localparam logic [4:0] HDR_FRAME_POS = 5'd5;
	localparam logic [7:0] LABEL_BASE    = 8'h31;

	// PWM scaling: signed 16-bit channel minus 16-bit unsigned bias fits 18 bits.
	localparam int PWM_DIFF_W = 18;
	localparam int PWM_MAG_W  = 17;
	// floor(x / 5) == (x * RECIP) >> RECIP_SHIFT for every x below 2**18
	localparam int PWM_RECIP_SHIFT = 19;
	localparam logic [PWM_MAG_W-1:0] PWM_RECIP = 17'd104858;
	localparam int PWM_PROD_W = 2 * PWM_MAG_W;

	// One channel echo: three result bytes and the PWM outcome of the last one
	typedef struct packed {
		logic [7:0] label;
		logic [7:0] high;
		logic [7:0] low;
		logic       pwm_valid;
		logic [7:0] pwm_value;
	} echo_t;

endpackage

FILE: hdl/rcfp_pwm_scale.sv
// PWM adjust scaler: low byte of a signed difference divided by five, toward zero.
module rcfp_pwm_scale (
	input  logic signed [rcfp_pkg::PWM_DIFF_W-1:0] diff,
	output logic        [7:0]                      value
);
	import rcfp_pkg::*;

	logic                    neg;
	logic [PWM_DIFF_W-1:0]   abs_full;
	logic [PWM_MAG_W-1:0]    mag;
	logic [PWM_PROD_W-1:0]   prod;
	logic [7:0]              quot_lo;

	assign neg      = diff[PWM_DIFF_W-1];
	assign abs_full = neg ? PWM_DIFF_W'(~diff + PWM_DIFF_W'(1)) : diff;
	assign mag      = abs_full[PWM_MAG_W-1:0];

	// Reciprocal multiply replaces the divide by five
	assign prod    = PWM_PROD_W'(mag) * PWM_PROD_W'(PWM_RECIP);
	assign quot_lo = prod[PWM_RECIP_SHIFT +: 8];

	// Restore the sign on the truncated quotient
	assign value = neg ? 8'(~quot_lo + 8'd1) : quot_lo;

endmodule

FILE: hdl/rc_channel_frame_parser_unit.sv
// Top level of the RC channel frame parser: header checks, channel assembly and echo output.
//
// The block takes one received byte per in request and echoes each completed
// 16-bit channel as three out requests: the label ('1' + channel index), the
// high byte, then the low byte, with last set on the low byte. On the final
// channel of a frame the low byte also carries pwm_valid and the PWM adjust
// value (low byte of (signed channel - pwm_bias) / 5, truncated toward zero).
// A byte passes through an input register, is parsed combinationally against
// the frame state and, when it completes a channel, loads a three-entry echo
// register. The echo register drains one result per cycle at the out port
// while out_ready is high. The next byte is taken into the input register
// while an echo is still draining, and moves on as soon as the echo register
// frees up on its last result. Configuration is to be written through cfg_we,
// cfg_index and cfg_data while the block is idle; the block itself does not
// enforce this. All registers reset to the standard frame format (start 0xFE,
// sender 0x01/0x01, frame 0x23, data at offset 10, bias 980).
module rc_channel_frame_parser_unit #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [rcfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rcfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	// received bytes
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       rx_byte,
	// echo results
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_byte,
	output logic                             last,
	output logic                             pwm_valid,
	output logic [7:0]                       pwm_value
);
	import rcfp_pkg::*;

	// data_count holds up to 2*NUM_CHANNELS-1 bytes of the current frame
	localparam int CNT_W = (NUM_CHANNELS > 1) ? $clog2(2 * NUM_CHANNELS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * NUM_CHANNELS - 1);

	// Configuration registers
	logic [7:0]  start_byte_q;
	logic [7:0]  sender_id_q;
	logic [7:0]  sender_class_q;
	logic [7:0]  frame_id_q;
	logic [4:0]  data_offset_q;
	logic [15:0] pwm_bias_q;

	// Frame state
	logic             in_frame_q, id_matched_q, class_matched_q, frame_matched_q;
	logic [4:0]       byte_offset_q;
	logic [CNT_W-1:0] data_count_q;
	logic [7:0]       pending_low_q;

	logic             in_frame_d, id_matched_d, class_matched_d, frame_matched_d;
	logic [4:0]       byte_offset_d;
	logic [CNT_W-1:0] data_count_d;
	logic [7:0]       pending_low_d;

	// Input register
	logic       valid_s1;
	logic [7:0] rx_s1;

	// Echo register
	echo_t      echo_q;
	echo_t      echo_d;
	logic [1:0] echo_cnt_q;

	logic       emit;
	logic       close_frame;
	logic       echo_free;
	logic       advance;
	logic [4:0] off_inc;
	logic [15:0] chan;
	logic signed [PWM_DIFF_W-1:0] pwm_diff;
	logic [7:0] pwm_scaled;

	// ------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q   <= RST_START_BYTE;
			sender_id_q    <= RST_SENDER_ID;
			sender_class_q <= RST_SENDER_CLASS;
			frame_id_q     <= RST_FRAME_ID;
			data_offset_q  <= RST_DATA_OFFSET;
			pwm_bias_q     <= RST_PWM_BIAS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_BYTE:   start_byte_q   <= cfg_data[7:0];
				REG_SENDER_ID:    sender_id_q    <= cfg_data[7:0];
				REG_SENDER_CLASS: sender_class_q <= cfg_data[7:0];
				REG_FRAME_ID:     frame_id_q     <= cfg_data[7:0];
				REG_DATA_OFFSET:  data_offset_q  <= cfg_data[4:0];
				REG_PWM_BIAS:     pwm_bias_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: the input register moves on when its byte makes no echo,
	// or when the echo register is empty or hands out its last result now.
	// ------------------------------------------------------------------
	assign echo_free = (echo_cnt_q == 2'd0) || ((echo_cnt_q == 2'd1) && out_ready);
	assign advance   = valid_s1 && (!emit || echo_free);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_s1 <= rx_byte;
		end
	end

	// ------------------------------------------------------------------
	// Parser: one byte against the frame state. Priority follows the frame
	// layout: start byte, then the three header bytes, then channel data.
	// ------------------------------------------------------------------
	assign off_inc  = (byte_offset_q < OFFSET_MAX) ? 5'(byte_offset_q + 5'd1) : byte_offset_q;
	assign chan     = {rx_s1, pending_low_q};
	assign pwm_diff = PWM_DIFF_W'(signed'(chan)) - signed'(PWM_DIFF_W'(pwm_bias_q));

	rcfp_pwm_scale u_pwm_scale (
		.diff  (pwm_diff),
		.value (pwm_scaled)
	);

	always_comb begin
		in_frame_d      = in_frame_q;
		id_matched_d    = id_matched_q;
		class_matched_d = class_matched_q;
		frame_matched_d = frame_matched_q;
		byte_offset_d   = off_inc;
		data_count_d    = data_count_q;
		pending_low_d   = pending_low_q;
		emit            = 1'b0;
		close_frame     = 1'b0;

		if (rx_s1 == start_byte_q) begin
			// restart the frame wherever the start byte shows up
			in_frame_d      = 1'b1;
			id_matched_d    = 1'b0;
			class_matched_d = 1'b0;
			frame_matched_d = 1'b0;
			data_count_d    = '0;
			byte_offset_d   = '0;
		end else if (rx_s1 == sender_id_q && in_frame_q && !id_matched_q &&
				off_inc == HDR_ID_POS) begin
			id_matched_d    = 1'b1;
			class_matched_d = 1'b0;
			frame_matched_d = 1'b0;
		end else if (rx_s1 == sender_class_q && in_frame_q && id_matched_q &&
				!class_matched_q && off_inc == HDR_CLASS_POS) begin
			class_matched_d = 1'b1;
			frame_matched_d = 1'b0;
		end else if (rx_s1 == frame_id_q && in_frame_q && id_matched_q && class_matched_q &&
				!frame_matched_q && off_inc == HDR_FRAME_POS) begin
			frame_matched_d = 1'b1;
		end else if (in_frame_q && id_matched_q && class_matched_q && frame_matched_q &&
				off_inc >= data_offset_q) begin
			if (!data_count_q[0]) begin
				// low byte of a channel: hold it until the high byte arrives
				pending_low_d = rx_s1;
				data_count_d  = CNT_W'(data_count_q + 1'b1);
			end else begin
				emit = 1'b1;
				if (data_count_q == CNT_LAST) begin
					close_frame     = 1'b1;
					in_frame_d      = 1'b0;
					id_matched_d    = 1'b0;
					class_matched_d = 1'b0;
					frame_matched_d = 1'b0;
					data_count_d    = '0;
					byte_offset_d   = '0;
				end else begin
					data_count_d = CNT_W'(data_count_q + 1'b1);
				end
			end
		end
	end

	always_comb begin
		echo_d.label     = 8'(LABEL_BASE + 8'(data_count_q >> 1));
		echo_d.high      = rx_s1;
		echo_d.low       = pending_low_q;
		echo_d.pwm_valid = close_frame;
		echo_d.pwm_value = close_frame ? pwm_scaled : 8'd0;
	end

	// Advance the frame state only when the byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q      <= 1'b0;
			id_matched_q    <= 1'b0;
			class_matched_q <= 1'b0;
			frame_matched_q <= 1'b0;
			byte_offset_q   <= '0;
			data_count_q    <= '0;
			pending_low_q   <= '0;
		end else if (advance) begin
			in_frame_q      <= in_frame_d;
			id_matched_q    <= id_matched_d;
			class_matched_q <= class_matched_d;
			frame_matched_q <= frame_matched_d;
			byte_offset_q   <= byte_offset_d;
			data_count_q    <= data_count_d;
			pending_low_q   <= pending_low_d;
		end
	end

	// ------------------------------------------------------------------
	// Echo register: load a full channel echo, then drain one result per
	// out request. echo_cnt_q counts the results still to go.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_cnt_q <= 2'd0;
		end else if (advance && emit) begin
			echo_cnt_q <= 2'd3;
		end else if (out_valid && out_ready) begin
			echo_cnt_q <= 2'(echo_cnt_q - 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			echo_q <= echo_d;
		end
	end

	assign out_valid = (echo_cnt_q != 2'd0);
	assign last      = (echo_cnt_q == 2'd1);
	assign pwm_valid = last && echo_q.pwm_valid;
	assign pwm_value = last ? echo_q.pwm_value : 8'd0;

	always_comb begin
		case (echo_cnt_q)
			2'd3:    out_byte = echo_q.label;
			2'd2:    out_byte = echo_q.high;
			2'd1:    out_byte = echo_q.low;
			default: out_byte = 8'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_pwm_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pwm_valid |-> (out_valid && last))
		else $error("pwm_valid outside the last echo byte");

	a_header_order: assert property (@(posedge clk) disable iff (!arst_n)
		frame_matched_q |-> (class_matched_q && id_matched_q && in_frame_q))
		else $error("frame id matched without the earlier header bytes");

	a_data_needs_header: assert property (@(posedge clk) disable iff (!arst_n)
		(data_count_q != '0) |-> frame_matched_q)
		else $error("channel bytes counted outside a matched frame");

	a_echo_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> (echo_cnt_q == 2'd0 || echo_cnt_q == 2'd3))
		else $error("echo register reloaded mid-echo");

endmodule

FILE: test/tb_rc_channel_frame_parser_unit.sv
// Self-checking testbench for the RC channel frame parser unit.
`timescale 1ns / 1ps

module tb_rc_channel_frame_parser_unit;
	import rcfp_pkg::*;

	localparam int NUM_CH       = 8;
	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 11;
	// covers the input register and the parse, with margin
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int WDOG_LIMIT   = 2000;
	localparam int DIR_LEN      = 26;

	// receiver stall patterns
	typedef enum int {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_PATTERN,
		RDY_MOSTLY
	} rdy_mode_t;

	// one echo byte as it leaves the block
	typedef struct packed {
		logic [7:0] data;
		logic       lst;
		logic       pv;
		logic [7:0] pval;
	} echo_byte_t;

	// directed row: received byte and, where chk is set, the typed-in channel echo
	typedef struct packed {
		logic [7:0] rx;
		logic       chk;
		logic [7:0] lbl;
		logic [7:0] hi;
		logic [7:0] lo;
		logic       pv;
		logic [7:0] pval;
	} dir_row_t;

	// A header with a wrong sender id, then a full frame at the standard ids with
	// data from offset 6: zero, all ones, mixed patterns and the signed extremes.
	// The last channel is 0x8000: (-32768 - 980) / 5 = -6749, low byte 0xA3.
	localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
		'{8'hFE, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h02, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'hFE, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h23, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h00, 1'b1, 8'h31, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'hFF, 1'b1, 8'h32, 8'hFF, 8'hFF, 1'b0, 8'h00},
		'{8'h34, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h12, 1'b1, 8'h33, 8'h12, 8'h34, 1'b0, 8'h00},
		'{8'h5A, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'hA5, 1'b1, 8'h34, 8'hA5, 8'h5A, 1'b0, 8'h00},
		'{8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h00, 1'b1, 8'h35, 8'h00, 8'hFF, 1'b0, 8'h00},
		'{8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'hFF, 1'b1, 8'h36, 8'hFF, 8'h00, 1'b0, 8'h00},
		'{8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h7F, 1'b1, 8'h37, 8'h7F, 8'hFF, 1'b0, 8'h00},
		'{8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
		'{8'h80, 1'b1, 8'h38, 8'h80, 8'h00, 1'b1, 8'hA3}
	};

	// DUT ports; every input starts at a known value
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte   = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           out_byte;
	logic                 last;
	logic                 pwm_valid;
	logic [7:0]           pwm_value;

	// predictor copy of the configuration
	logic [7:0]  want_start;
	logic [7:0]  want_id;
	logic [7:0]  want_class;
	logic [7:0]  want_frame;
	logic [4:0]  want_doff;
	logic [15:0] want_bias;

	// predictor copy of the parser state
	logic        frame_open;
	logic        id_seen;
	logic        class_seen;
	logic        frame_seen;
	logic [4:0]  pos;
	logic [4:0]  chan_bytes;
	logic [7:0]  low_hold;

	echo_byte_t  new_echo [3];
	echo_byte_t  echo_q [$];
	echo_byte_t  want;

	// traffic shaping
	rdy_mode_t   rdy_mode    = RDY_ALWAYS;
	int          gap_max     = 0;
	int          burst_left  = 0;
	bit          hold_req    = 1'b0;
	int          hold_left   = 0;
	int          pat_cnt     = 0;
	logic        rdy_next;

	// bookkeeping
	int          errors      = 0;
	int          quiet_cycles = 0;
	int          n_rx        = 0;
	int          n_echo      = 0;
	int          n_frames    = 0;
	int          n_settings  = 0;
	int          sent        = 0;

	rc_channel_frame_parser_unit #(
		.NUM_CHANNELS(NUM_CH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last),
		.pwm_valid (pwm_valid),
		.pwm_value (pwm_value)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Low byte of (signed channel - bias) / 5; int division truncates toward zero.
	function automatic logic [7:0] pwm_adjust(input logic [15:0] chan);
		int diff;
		int q;
		diff = int'(shortint'(chan)) - int'(want_bias);
		q = diff / 5;
		return q[7:0];
	endfunction

	function automatic void drop_frame();
		frame_open = 1'b0;
		id_seen    = 1'b0;
		class_seen = 1'b0;
		frame_seen = 1'b0;
		chan_bytes = '0;
		pos        = '0;
	endfunction

	// Advance the parser by one received byte; return how many echo bytes it
	// causes and leave them in new_echo.
	function automatic int parse_byte(input logic [7:0] rx);
		int n;
		int idx;
		logic [15:0] chan;
		if (pos < OFFSET_MAX)
			pos = pos + 5'd1;
		if (rx == want_start) begin
			frame_open = 1'b1;
			id_seen    = 1'b0;
			class_seen = 1'b0;
			frame_seen = 1'b0;
			chan_bytes = '0;
			pos        = '0;
			return 0;
		end
		if (rx == want_id && frame_open && !id_seen && pos == HDR_ID_POS) begin
			id_seen    = 1'b1;
			class_seen = 1'b0;
			frame_seen = 1'b0;
			return 0;
		end
		if (rx == want_class && frame_open && id_seen && !class_seen &&
				pos == HDR_CLASS_POS) begin
			class_seen = 1'b1;
			frame_seen = 1'b0;
			return 0;
		end
		if (rx == want_frame && frame_open && id_seen && class_seen && !frame_seen &&
				pos == HDR_FRAME_POS) begin
			frame_seen = 1'b1;
			return 0;
		end
		if (!(frame_open && id_seen && class_seen && frame_seen && pos >= want_doff))
			return 0;
		n = int'(chan_bytes) + 1;
		if (n % 2 == 1) begin
			// low byte: hold until the high byte completes the channel
			low_hold   = rx;
			chan_bytes = 5'(n);
			return 0;
		end
		idx  = n / 2 - 1;
		chan = {rx, low_hold};
		new_echo[0] = '{8'(LABEL_BASE + idx), 1'b0, 1'b0, 8'h00};
		new_echo[1] = '{rx, 1'b0, 1'b0, 8'h00};
		if (n >= 2 * NUM_CH) begin
			new_echo[2] = '{low_hold, 1'b1, 1'b1, pwm_adjust(chan)};
			drop_frame();
		end else begin
			new_echo[2] = '{low_hold, 1'b1, 1'b0, 8'h00};
			chan_bytes  = 5'(n);
		end
		return 3;
	endfunction

	// Offer one byte as a request, honoring the burst and gap pattern, and hold
	// it until the block takes it.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		n_rx++;
	endtask

	// Send a byte and queue what the predictor says it produces.
	task automatic feed(input logic [7:0] b);
		int n;
		send_byte(b);
		n = parse_byte(b);
		for (int i = 0; i < n; i++)
			echo_q.push_back(new_echo[i]);
	endtask

	// Stop offering, wait for every expected echo and let the pipeline empty.
	task automatic drain();
		in_valid  <= 1'b0;
		burst_left = 0;
		while (echo_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all six registers, one per cycle, and mirror them in the predictor.
	task automatic apply_setting(input logic [7:0] sb, input logic [7:0] id,
			input logic [7:0] cls, input logic [7:0] fid, input logic [4:0] doff,
			input logic [15:0] bias);
		logic [CFG_DATA_W-1:0] vals [6];
		logic [CFG_IDX_W-1:0]  regs [6];
		regs = '{REG_START_BYTE, REG_SENDER_ID, REG_SENDER_CLASS, REG_FRAME_ID,
			REG_DATA_OFFSET, REG_PWM_BIAS};
		vals = '{16'(sb), 16'(id), 16'(cls), 16'(fid), 16'(doff), bias};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			case (regs[i])
				REG_START_BYTE:   want_start = vals[i][7:0];
				REG_SENDER_ID:    want_id    = vals[i][7:0];
				REG_SENDER_CLASS: want_class = vals[i][7:0];
				REG_FRAME_ID:     want_frame = vals[i][7:0];
				REG_DATA_OFFSET:  want_doff  = vals[i][4:0];
				REG_PWM_BIAS:     want_bias  = vals[i];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Random byte that cannot restart the frame.
	function automatic logic [7:0] body_byte();
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == want_start);
		return v;
	endfunction

	// Random byte different from both the start byte and the given header byte.
	function automatic logic [7:0] wrong_byte(input logic [7:0] good);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == want_start || v == good);
		return v;
	endfunction

	// Build one frame with random content and send it; optionally corrupt a
	// header byte or cut it short, which leaves the frame open for what follows.
	task automatic send_frame(input bit bad_hdr, input int cut);
		logic [7:0] fb [$];
		int k;
		fb.push_back(want_start);
		fb.push_back(body_byte());
		fb.push_back(body_byte());
		fb.push_back(want_id);
		fb.push_back(want_class);
		fb.push_back(want_frame);
		// filler up to the first data byte; channel data never starts before 6
		while (fb.size() < int'(want_doff))
			fb.push_back(body_byte());
		for (int i = 0; i < 2 * NUM_CH; i++)
			fb.push_back(body_byte());
		if (bad_hdr) begin
			k     = $urandom_range(3, 5);
			fb[k] = wrong_byte(fb[k]);
		end
		if (cut > 0 && cut < fb.size())
			fb = fb[0:cut-1];
		foreach (fb[i]) begin
			feed(fb[i]);
			sent++;
		end
	endtask

	// Mostly well-formed frames, some broken ones, some stray bytes.
	task automatic random_traffic(input int items);
		int pick;
		int len;
		logic [7:0] b;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				send_frame(1'b0, 0);
			end else if (pick == 7) begin
				if ($urandom_range(0, 1) == 1)
					send_frame(1'b1, 0);
				else
					send_frame(1'b0, $urandom_range(1, 30));
			end else begin
				len = $urandom_range(1, 6);
				repeat (len) begin
					b = ($urandom_range(0, 3) == 0) ? want_start : 8'($urandom_range(0, 255));
					feed(b);
					sent++;
				end
			end
		end
	endtask

	// Receiver: long hold-off on request, otherwise the current stall pattern.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy_next = 1'b0;
		end else begin
			case (rdy_mode)
				RDY_ALWAYS:  rdy_next = 1'b1;
				RDY_COIN:    rdy_next = 1'($urandom_range(0, 1));
				RDY_PATTERN: rdy_next = (pat_cnt % 8) < 3;
				RDY_MOSTLY:  rdy_next = $urandom_range(0, 7) != 0;
				default:     rdy_next = 1'b1;
			endcase
		end
		pat_cnt++;
		out_ready <= rdy_next;
	end

	// Compare each accepted echo byte with the oldest expectation.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			n_echo++;
			if (echo_q.size() == 0) begin
				$error("unexpected echo byte: out_byte %h last %b pwm_valid %b",
					out_byte, last, pwm_valid);
				errors++;
			end else begin
				want = echo_q.pop_front();
				if (want.pv)
					n_frames++;
				if (out_byte !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, out_byte);
					errors++;
				end
				if (last !== want.lst) begin
					$error("last: expected %b, got %b", want.lst, last);
					errors++;
				end
				if (pwm_valid !== want.pv) begin
					$error("pwm_valid: expected %b, got %b", want.pv, pwm_valid);
					errors++;
				end
				if (pwm_value !== want.pval) begin
					$error("pwm_value: expected %h, got %h", want.pval, pwm_value);
					errors++;
				end
			end
		end
	end

	// Count cycles in which no request moves on any port.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		wait (quiet_cycles >= WDOG_LIMIT);
		$display("stalled for %0d cycles with %0d echo bytes outstanding",
			quiet_cycles, echo_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int n;
		dir_row_t row;
		logic [7:0] sb;

		want_start = RST_START_BYTE;
		want_id    = RST_SENDER_ID;
		want_class = RST_SENDER_CLASS;
		want_frame = RST_FRAME_ID;
		want_doff  = RST_DATA_OFFSET;
		want_bias  = RST_PWM_BIAS;
		low_hold   = 8'h00;
		drop_frame();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: standard ids, channel data moved up to offset 6.
		apply_setting(RST_START_BYTE, RST_SENDER_ID, RST_SENDER_CLASS, RST_FRAME_ID,
			5'd6, RST_PWM_BIAS);
		rdy_mode = RDY_COIN;
		gap_max  = 3;
		for (int r = 0; r < DIR_LEN; r++) begin
			row = DIR_ROWS[r];
			send_byte(row.rx);
			n = parse_byte(row.rx);
			if (row.chk) begin
				echo_q.push_back('{row.lbl, 1'b0, 1'b0, 8'h00});
				echo_q.push_back('{row.hi, 1'b0, 1'b0, 8'h00});
				echo_q.push_back('{row.lo, 1'b1, row.pv, row.pval});
			end else begin
				for (int i = 0; i < n; i++)
					echo_q.push_back(new_echo[i]);
			end
		end
		drain();

		// Reset format with the receiver held off long enough to back up the input.
		apply_setting(RST_START_BYTE, RST_SENDER_ID, RST_SENDER_CLASS, RST_FRAME_ID,
			RST_DATA_OFFSET, RST_PWM_BIAS);
		rdy_mode = RDY_MOSTLY;
		gap_max  = 2;
		hold_req = 1'b1;
		random_traffic(70);
		drain();

		// Start byte zero, data at the saturated offset, no bias.
		apply_setting(8'h00, 8'hFF, 8'h80, 8'h7F, 5'd31, 16'h0000);
		rdy_mode = RDY_PATTERN;
		gap_max  = 4;
		random_traffic(40);
		drain();

		// All-ones start byte, earliest legal data offset, largest bias; no idling.
		apply_setting(8'hFF, 8'h00, 8'h55, 8'hAA, 5'd6, 16'hFFFF);
		rdy_mode = RDY_ALWAYS;
		gap_max  = 0;
		random_traffic(45);
		drain();

		// Data offset below the header end, random ids and bias.
		sb = 8'($urandom_range(0, 255));
		want_start = sb;
		apply_setting(sb, wrong_byte(sb), wrong_byte(sb), wrong_byte(sb),
			5'($urandom_range(0, 5)), 16'($urandom_range(0, 65535)));
		rdy_mode = RDY_COIN;
		gap_max  = 6;
		random_traffic(45);
		drain();

		// Fully random setting.
		sb = 8'($urandom_range(0, 255));
		want_start = sb;
		apply_setting(sb, wrong_byte(sb), wrong_byte(sb), wrong_byte(sb),
			5'($urandom_range(6, 31)), 16'($urandom_range(0, 65535)));
		rdy_mode = RDY_MOSTLY;
		gap_max  = 3;
		random_traffic(40);
		drain();

		if (echo_q.size() != 0) begin
			$error("%0d expected echo bytes never arrived", echo_q.size());
			errors++;
		end

		$display("Sent %0d bytes under %0d register settings; checked %0d echo bytes, %0d frames",
			n_rx, n_settings, n_echo, n_frames);
		$display("Data offsets from below the header to saturation, bias and id extremes");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
hdl/rcfp_pkg.sv
hdl/rcfp_pwm_scale.sv
hdl/rc_channel_frame_parser_unit.sv
test/tb_rc_channel_frame_parser_unit.sv
